### rtl/core/cdee_pkg.sv
package cdee_pkg;

  localparam int CENTRE_W = 10;
  localparam int MID_W    = 8;
  localparam int PIXEL_W  = 8;
  localparam int POINT_W  = 12;
  localparam int SUM_W    = 14;
  localparam int COUNT_W  = 8;
  localparam int PROD_W   = 2 * COUNT_W;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [MID_W-1:0]   MID_RESET = 8'd51;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID    = 1'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

### rtl/core/cdee_if.sv
interface cdee_pix_if;
  import cdee_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               column_end;

  modport source (output valid, output pixel, output column_end, input ready);
  modport sink   (input valid, input pixel, input column_end, output ready);
endinterface

interface cdee_pt_if;
  import cdee_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [POINT_W-1:0] point;

  modport source (output valid, output point, input ready);
  modport sink   (input valid, input point, output ready);
endinterface

### rtl/core/cdee_mul.sv
// Shift-add multiplier: one multiplier bit per cycle, MSB first.
module cdee_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [cdee_pkg::COUNT_W-1:0]   mcand,
  input  logic [cdee_pkg::MID_W-1:0]     mplier,
  output logic [cdee_pkg::PROD_W-1:0]    product,
  output cdee_pkg::mul_stat_t            stat
);
  import cdee_pkg::*;

  localparam int BIT_W = $clog2(MID_W);

  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              busy_r, busy_nxt;
  logic [PROD_W-1:0] addend;

  always_comb begin
    addend   = mplier[bit_r] ? {{(PROD_W-COUNT_W){1'b0}}, mcand} : '0;
    acc_nxt  = acc_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt  = '0;
      bit_nxt  = BIT_W'(MID_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[PROD_W-2:0], 1'b0} + addend;
      bit_nxt = bit_r - 1'b1;
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    acc_r <= acc_nxt;
    bit_r <= bit_nxt;
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = busy_r && (bit_r == '0);

endmodule

### rtl/core/column_doppler_edge_extract.sv
// Channel   Dir  Word                  Notes
// in_ch     in   pixel, column_end     one pixel per word, top row first
// out_ch    out  point (signed 12)     one word per finished column
// cfg_*     in   index, data           centre_bin (0), mid_row (1)
//
// Pixels go in at one per cycle while the block accumulates. A column-end word
// closes the input: the block accepts it, runs the shift-add multiply of mid_row by
// the marked count (mean >= mid_row is tested as sum >= mid_row * count), then finishes.
// An empty column skips the multiply. The finish step waits while
// the previous point is still held in the output register.
// Synchronous active-low reset clears the accumulators and sets mid_row to 51.
module column_doppler_edge_extract #(
  parameter int ROWS = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cdee_pix_if.sink                        in_ch,
  cdee_pt_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [cdee_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cdee_pkg::CFG_W-1:0]      cfg_wdata
);
  import cdee_pkg::*;

  localparam int CNT_W = $clog2(ROWS);
  localparam int ROW_W = $clog2(ROWS + 1);
  localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(ROWS - 1);

  localparam logic [1:0] ST_ACC = 2'd0;
  localparam logic [1:0] ST_MUL = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CENTRE_W-1:0] centre_r;
  logic [MID_W-1:0]    mid_r;
  logic [CNT_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [ROW_W-1:0]    high_r, high_nxt;
  logic [ROW_W-1:0]    low_r, low_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [POINT_W-1:0]  point_r, point_nxt;

  logic                in_acc;
  logic                marked;
  logic [ROW_W-1:0]    row1;
  logic [SUM_W:0]      sum_ext;
  logic                mul_start;
  logic [PROD_W-1:0]   product;
  mul_stat_t           mul_stat;
  logic                mean_ge;
  logic [ROW_W-1:0]    edge_row;
  logic [POINT_W-1:0]  point_calc;
  logic                load_out;

  cdee_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (count_r),
    .mplier  (mid_r),
    .product (product),
    .stat    (mul_stat)
  );

  assign in_ch.ready  = (state_r == ST_ACC);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign marked       = (in_ch.pixel != '0);
  assign row1         = ROW_W'(row_cnt_r) + ROW_W'(1);
  assign sum_ext      = {1'b0, sum_r} + (SUM_W + 1)'(row1);

  assign mean_ge    = ({{(PROD_W-SUM_W){1'b0}}, sum_r} >= product);
  assign edge_row   = mean_ge ? high_r : low_r;
  assign point_calc = (count_r == '0) ? POINT_W'(centre_r)
                    : POINT_W'(edge_row) + POINT_W'(centre_r) - POINT_W'(mid_r);
  assign load_out   = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    out_valid_nxt = out_valid_r;
    point_nxt     = point_r;
    mul_start     = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_ACC: begin
        if (in_acc) begin
          if (marked) begin
            sum_nxt   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
            count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
            if (row1 > high_r) begin
              high_nxt = row1;
            end
            if (count_r == '0 || row1 < low_r) begin
              low_nxt = row1;
            end
          end
          if (in_ch.column_end) begin
            // empty column needs no mean test
            if (count_nxt == '0) begin
              state_nxt = ST_FIN;
            end else begin
              state_nxt = ST_MUL;
              mul_start = 1'b1;
            end
          end else if (row_cnt_r < LAST_ROW) begin
            row_cnt_nxt = row_cnt_r + 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          point_nxt     = point_calc;
          row_cnt_nxt   = '0;
          sum_nxt       = '0;
          count_nxt     = '0;
          high_nxt      = '0;
          low_nxt       = '1;
          state_nxt     = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      row_cnt_r   <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      high_r      <= '0;
      low_r       <= '1;
      out_valid_r <= 1'b0;
      centre_r    <= '0;
      mid_r       <= MID_RESET;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_CENTRE: centre_r <= cfg_wdata[CENTRE_W-1:0];
          REG_MID:    mid_r    <= cfg_wdata[MID_W-1:0];
          default: ;
        endcase
      end
    end
    point_r <= point_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.point = point_r;

endmodule

### rtl/core/cdee_check.sv
module cdee_check (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_column_end,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [cdee_pkg::POINT_W-1:0] out_point
);

  // a held point must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point))
    else $error("point changed while stalled");

  // column end closes the input until the point is computed
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_column_end |=> !in_ready)
    else $error("input taken right after column end");

  // a point only appears from the finish step, never while pixels flow
  a_no_spur: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |=> !$rose(out_valid))
    else $error("point produced while accepting pixels");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind column_doppler_edge_extract cdee_check u_cdee_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_column_end (in_ch.column_end),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_point     (out_ch.point)
);

### tb/sv/tb_column_doppler_edge_extract.sv
`timescale 1ns / 1ps
module tb_column_doppler_edge_extract;
  import cdee_pkg::*;

  localparam int ROWS_N         = 128;
  localparam int ROW_W          = $clog2(ROWS_N);
  localparam int RAND_WORDS     = 1930;
  localparam int COLS_PER_PHASE = 3;
  localparam int IDLE_PCT       = 38;
  localparam int HOLD_AT_POINT  = 8;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 24;
  localparam int N_FIXED_CFG    = 6;

  typedef struct packed {
    logic [PIXEL_W-1:0] pix;
    logic               col_end;
    logic               typed;
    logic [POINT_W-1:0] pt;
  } dir_row_t;

  // reset config: centre_bin 0, mid_row 51
  localparam int DIR_N = 21;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{8'h00, 1'b1, 1'b1, 12'h000},  // empty one-row column gives centre
    '{8'hFF, 1'b1, 1'b1, 12'hFCE},  // top row only: 1 - 51
    '{8'h01, 1'b0, 1'b0, 12'h000},
    '{8'h00, 1'b0, 1'b0, 12'h000},
    '{8'h80, 1'b1, 1'b0, 12'h000},
    '{8'h55, 1'b0, 1'b0, 12'h000},
    '{8'hAA, 1'b0, 1'b0, 12'h000},
    '{8'h0F, 1'b0, 1'b0, 12'h000},
    '{8'hF0, 1'b1, 1'b0, 12'h000},
    '{8'h00, 1'b0, 1'b0, 12'h000},
    '{8'h00, 1'b0, 1'b0, 12'h000},
    '{8'h00, 1'b1, 1'b1, 12'h000},  // empty column
    '{8'hFE, 1'b0, 1'b0, 12'h000},
    '{8'h7F, 1'b1, 1'b0, 12'h000},
    '{8'h00, 1'b0, 1'b0, 12'h000},
    '{8'h02, 1'b0, 1'b0, 12'h000},
    '{8'h04, 1'b0, 1'b0, 12'h000},
    '{8'h08, 1'b0, 1'b0, 12'h000},
    '{8'h10, 1'b0, 1'b0, 12'h000},
    '{8'h20, 1'b0, 1'b0, 12'h000},
    '{8'h40, 1'b1, 1'b0, 12'h000}
  };

  localparam logic [CENTRE_W-1:0] FIXED_CENTRE [N_FIXED_CFG] =
    '{10'd1023, 10'd0, 10'd0, 10'd1023, 10'd517, 10'd0};
  localparam logic [MID_W-1:0] FIXED_MID [N_FIXED_CFG] =
    '{8'd128, 8'd0, 8'd128, 8'd0, 8'd64, 8'd51};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  cdee_pix_if pix_ch ();
  cdee_pt_if  pt_ch ();

  column_doppler_edge_extract #(.ROWS(ROWS_N)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_ch),
    .out_ch    (pt_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // column tracker shadow
  logic [CENTRE_W-1:0] centre_q;
  logic [MID_W-1:0]    mid_q;
  logic [ROW_W-1:0]    row_q;
  logic [SUM_W-1:0]    sum_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [7:0]          hi_q;
  logic [7:0]          lo_q;

  logic [POINT_W-1:0] pending_points [$];
  int err_cnt      = 0;
  int words_sent   = 0;
  int points_seen  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("column_doppler_edge_extract verification failed");
    $finish;
  end

  function automatic void clear_column();
    row_q = '0;
    sum_q = '0;
    cnt_q = '0;
    hi_q  = '0;
    lo_q  = '1;
  endfunction

  // folds one pixel into the column; returns 1 with the point on column end
  function automatic bit fold_pixel(input logic [PIXEL_W-1:0] pix, input logic col_end,
                                    output logic [POINT_W-1:0] pt);
    int row1;
    int sum_n;
    int mean;
    int edge_row;
    int raw;
    row1 = int'(row_q) + 1;
    pt = '0;
    if (pix != '0) begin
      sum_n = int'(sum_q) + row1;
      sum_q = (sum_n > int'(SUM_MAX)) ? SUM_MAX : sum_n[SUM_W-1:0];
      if (cnt_q != COUNT_MAX) cnt_q = cnt_q + 1'b1;
      if (row1 > int'(hi_q)) hi_q = row1[7:0];
      if (cnt_q == 1 || row1 < int'(lo_q)) lo_q = row1[7:0];
    end
    if (!col_end) begin
      // overlong columns pile onto the last row
      if (int'(row_q) < ROWS_N - 1) row_q = row_q + 1'b1;
      return 1'b0;
    end
    if (cnt_q == '0) begin
      pt = POINT_W'(centre_q);
    end else begin
      mean = int'(sum_q) / int'(cnt_q);
      edge_row = (mean >= int'(mid_q)) ? int'(hi_q) : int'(lo_q);
      raw = edge_row + int'(centre_q) - int'(mid_q);
      pt = raw[POINT_W-1:0];
    end
    clear_column();
    return 1'b1;
  endfunction

  task automatic send_word(input logic [PIXEL_W-1:0] pix, input logic col_end,
                           input logic typed, input logic [POINT_W-1:0] typed_pt);
    logic [POINT_W-1:0] pt;
    bit calm;
    calm = (words_sent >= 700 && words_sent < 1100);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid      <= 1'b1;
    pix_ch.pixel      <= pix;
    pix_ch.column_end <= col_end;
    do @(posedge clk); while (!pix_ch.ready);
    if (fold_pixel(pix, col_end, pt))
      pending_points.insert(pending_points.size(), typed ? typed_pt : pt);
    words_sent++;
  endtask

  task automatic send_column(input int len, input int dens, input int band_lo,
                             input int band_hi);
    logic [PIXEL_W-1:0] pix;
    for (int r = 0; r < len; r++) begin
      if ($urandom_range(0, 19) == 0) begin
        pix = PIXEL_W'($urandom_range(0, 255));
      end else if (r >= band_lo && r <= band_hi && $urandom_range(0, 99) < dens) begin
        pix = PIXEL_W'($urandom_range(1, 255));
      end else begin
        pix = '0;
      end
      send_word(pix, r == len - 1, 1'b0, '0);
    end
  endtask

  task automatic random_column();
    int sel;
    int len;
    int dens;
    int lo_r;
    int hi_r;
    sel = $urandom_range(0, 99);
    if (sel < 30) len = ROWS_N;
    else if (sel < 75) len = $urandom_range(1, 40);
    else if (sel < 88) len = $urandom_range(41, ROWS_N - 1);
    else len = $urandom_range(ROWS_N + 1, 320);
    case ($urandom_range(0, 4))
      0: dens = 0;
      1: dens = 10;
      2: dens = 50;
      3: dens = 90;
      default: dens = 100;
    endcase
    lo_r = $urandom_range(0, len - 1);
    hi_r = $urandom_range(lo_r, len - 1);
    if ($urandom_range(0, 3) == 0 || (len > ROWS_N && $urandom_range(0, 1) == 0)) begin
      lo_r = 0;
      hi_r = len - 1;
      if (len > ROWS_N) dens = 100;
    end
    send_column(len, dens, lo_r, hi_r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == REG_CENTRE) centre_q = data[CENTRE_W-1:0];
    else mid_q = data[MID_W-1:0];
  endtask

  // block goes idle once every point is back and the finish path has drained
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // point sink: random stalls (none while words 700 to 1099 go in), one long hold to back up the pixel side
  initial begin
    int hold_left;
    bit held;
    logic [POINT_W-1:0] want;
    hold_left = 0;
    held = 1'b0;
    pt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pt_ch.valid && pt_ch.ready) begin
        if (pending_points.size() == 0) begin
          $error("point word with no expectation: actual %0d", $signed(pt_ch.point));
          err_cnt++;
        end else begin
          want = pending_points.pop_front();
          if (pt_ch.point !== want) begin
            $error("point mismatch: expected %0d actual %0d", $signed(want),
                   $signed(pt_ch.point));
            err_cnt++;
          end
        end
        points_seen++;
      end
      if (!held && points_seen == HOLD_AT_POINT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pt_ch.ready <= 1'b0;
      end else if (words_sent >= 700 && words_sent < 1100) begin
        pt_ch.ready <= 1'b1;
      end else begin
        pt_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int phase;
    int rand_start;
    logic [CENTRE_W-1:0] cb;
    logic [MID_W-1:0] mr;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_wdata         <= '0;
    pix_ch.valid      <= 1'b0;
    pix_ch.pixel      <= '0;
    pix_ch.column_end <= 1'b0;
    centre_q = '0;
    mid_q    = MID_RESET;
    clear_column();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TAB[i])
      send_word(DIR_TAB[i].pix, DIR_TAB[i].col_end, DIR_TAB[i].typed, DIR_TAB[i].pt);

    rand_start = words_sent;
    phase = 0;
    while (words_sent - rand_start < RAND_WORDS) begin
      settle();
      if (phase < N_FIXED_CFG) begin
        cb = FIXED_CENTRE[phase];
        mr = FIXED_MID[phase];
      end else begin
        cb = CENTRE_W'($urandom_range(0, 1023));
        mr = MID_W'($urandom_range(0, 128));
      end
      write_reg(REG_CENTRE, CFG_W'(cb));
      write_reg(REG_MID, CFG_W'(mr));
      cfg_we <= 1'b0;
      if (phase == 0) begin
        // saturates sum and count; then a band of marks lies past the last row
        send_column(300, 100, 0, 299);
        send_column(170, 100, 140, 169);
      end
      for (int c = 0; c < COLS_PER_PHASE && words_sent - rand_start < RAND_WORDS; c++)
        random_column();
      phase++;
    end
    settle();

    if (err_cnt == 0) begin
      $display("column_doppler_edge_extract verification clean");
    end else begin
      $display("column_doppler_edge_extract verification failed");
    end
    $finish;
  end

endmodule
